[hdl/i2c_target_rtc_bitbang_defines.svh]
// ---------------------------------------------------------------------------
// i2c_target_rtc_bitbang assertion macros
// Shared property shorthands for the block's checkers.
// ---------------------------------------------------------------------------
`ifndef I2C_TARGET_RTC_BITBANG_DEFINES_SVH
`define I2C_TARGET_RTC_BITBANG_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RTC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2c_target_rtc_bitbang: property violated");

// next-cycle implication, disabled during reset
`define RTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2c_target_rtc_bitbang: property violated");

`endif

[hdl/i2c_rtc_pkg.sv]
// ---------------------------------------------------------------------------
// i2c_rtc_pkg
// Payload types, bus phase codes, access codes and BCD helper.
// ---------------------------------------------------------------------------
`default_nettype none

package i2c_rtc_pkg;

  localparam logic [1:0] CMD_WR_SCL = 2'd0;
  localparam logic [1:0] CMD_WR_SDA = 2'd1;
  localparam logic [1:0] CMD_RD_SCL = 2'd2;
  localparam logic [1:0] CMD_RD_SDA = 2'd3;

  localparam logic [7:0] READ_MARK = 8'hFE;
  localparam logic [7:0] BYTE_IDLE = 8'hFF;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_ADDR     = 5'b00010,
    PH_ADDR_ACK = 5'b00100,
    PH_DATA     = 5'b01000,
    PH_DATA_ACK = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       line_value;
    logic [5:0] now_seconds;
    logic [5:0] now_minutes;
    logic [4:0] now_hours;
    logic [2:0] now_weekday;
    logic [4:0] now_day;
    logic [3:0] now_month;
    logic [6:0] now_year;
  } in_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       sda_level;
    logic       target_selected;
  } out_t;

  // divide by ten through the reciprocal 205/2048, exact below 1029
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = 8'(v) - 8'(tens) * 8'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

[hdl/i2c_target_rtc_bitbang.sv]
// ---------------------------------------------------------------------------
// i2c_target_rtc_bitbang
// Bit-banged I2C clock target: port accesses in, line read-back out.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carries one CPU port access per transfer (cmd,
//   line_value and the binary time). out_valid/out_stall returns one result
//   per access: read-back byte, data line level and target selection.
//   cfg_valid/cfg_ready writes the 7-bit target address; cfg_ready is
//   high outside reset, and writes are expected only while the block is idle.
// Throughput: one access per cycle while in_stall is low; the whole bus and
//   register update is one pass of logic between the state registers and output register.
// Stall: a two-entry output stage (output register plus skid) absorbs one
//   extra access while out_stall is high; in_stall rises only when both
//   entries are full and falls once the output is taken.
// Reset: synchronous rst returns the bus to idle, lines released, pointer
//   and clock registers to zero and the address to 104; in_stall is high
//   and cfg_ready is low while rst is asserted.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_target_rtc_bitbang #(
  parameter int REG_COUNT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire i2c_rtc_pkg::in_t  in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      i2c_rtc_pkg::out_t out_data,
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire logic [6:0]        cfg_data
);

  logic [6:0]          target_address;
  logic                clock_line, clock_line_next;
  logic                master_data_line, master_data_line_next;
  logic                target_data_drive, target_data_drive_next;
  i2c_rtc_pkg::phase_t bus_phase, bus_phase_next;
  logic [3:0]          bit_counter, bit_counter_next;
  logic [7:0]          shift_byte, shift_byte_next;
  logic                read_direction, read_direction_next;
  logic [7:0]          outgoing_byte, outgoing_byte_next;
  logic [2:0]          register_pointer, register_pointer_next;
  logic                pointer_loaded, pointer_loaded_next;
  logic                target_active, target_active_next;
  logic [7:0]          time_registers [REG_COUNT];

  logic [7:0]          cap_vals [8];
  logic                capture;
  logic [7:0]          fetch_cap, fetch_cur;
  logic                bus_now, sending;
  logic [3:0]          cnt_inc;
  logic [7:0]          read_value;
  i2c_rtc_pkg::out_t   result;

  logic                accept, out_take;
  logic                skid_valid;
  i2c_rtc_pkg::out_t   skid_data;

  assign cfg_ready = !rst;
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = skid_valid || rst;

  always_comb begin
    cap_vals[0] = i2c_rtc_pkg::to_bcd({1'b0, in_data.now_seconds});
    cap_vals[1] = i2c_rtc_pkg::to_bcd({1'b0, in_data.now_minutes});
    cap_vals[2] = i2c_rtc_pkg::to_bcd({2'b00, in_data.now_hours});
    cap_vals[3] = i2c_rtc_pkg::to_bcd(7'(in_data.now_weekday) + 7'd1);
    cap_vals[4] = i2c_rtc_pkg::to_bcd({2'b00, in_data.now_day});
    cap_vals[5] = i2c_rtc_pkg::to_bcd(7'(in_data.now_month) + 7'd1);
    cap_vals[6] = i2c_rtc_pkg::to_bcd(in_data.now_year);
    cap_vals[7] = 8'h00;
  end

  always_comb begin
    fetch_cap = (int'(register_pointer) < REG_COUNT) ? cap_vals[register_pointer] : 8'h00;
    fetch_cur = 8'h00;
    for (int i = 0; i < REG_COUNT; i++) begin
      if ({1'b0, register_pointer} == 4'(i)) begin
        fetch_cur = time_registers[i];
      end
    end
  end

  always_comb begin
    clock_line_next        = clock_line;
    master_data_line_next  = master_data_line;
    target_data_drive_next = target_data_drive;
    bus_phase_next         = bus_phase;
    bit_counter_next       = bit_counter;
    shift_byte_next        = shift_byte;
    read_direction_next    = read_direction;
    outgoing_byte_next     = outgoing_byte;
    register_pointer_next  = register_pointer;
    pointer_loaded_next    = pointer_loaded;
    target_active_next     = target_active;
    capture                = 1'b0;
    read_value             = 8'h00;
    bus_now                = master_data_line & target_data_drive;
    sending                = read_direction & target_active;
    cnt_inc                = bit_counter + 4'd1;

    unique case (in_data.cmd)
      i2c_rtc_pkg::CMD_WR_SCL: begin
        if (in_data.line_value != clock_line) begin
          clock_line_next = in_data.line_value;
          if (in_data.line_value) begin
            if (bus_phase == i2c_rtc_pkg::PH_ADDR || bus_phase == i2c_rtc_pkg::PH_DATA) begin
              shift_byte_next  = {shift_byte[6:0], bus_now};
              bit_counter_next = cnt_inc;
              if (cnt_inc >= 4'd8) begin
                bit_counter_next = 4'd8;
                if (bus_phase == i2c_rtc_pkg::PH_ADDR) begin
                  read_direction_next = shift_byte_next[0];
                  target_active_next  = (shift_byte_next[7:1] == target_address);
                  if (target_active_next) begin
                    capture             = 1'b1;
                    pointer_loaded_next = 1'b0;
                    if (read_direction_next) begin
                      outgoing_byte_next    = fetch_cap;
                      register_pointer_next = register_pointer + 3'd1;
                    end
                  end
                  bus_phase_next = i2c_rtc_pkg::PH_ADDR_ACK;
                end else begin
                  if (target_active && !read_direction) begin
                    if (!pointer_loaded) begin
                      register_pointer_next = shift_byte_next[2:0];
                      pointer_loaded_next   = 1'b1;
                    end else begin
                      register_pointer_next = register_pointer + 3'd1;
                    end
                  end
                  bus_phase_next = i2c_rtc_pkg::PH_DATA_ACK;
                end
              end
            end else if (bus_phase == i2c_rtc_pkg::PH_DATA_ACK) begin
              if (bit_counter == 4'd9 && sending) begin
                if (!master_data_line) begin
                  outgoing_byte_next    = fetch_cur;
                  register_pointer_next = register_pointer + 3'd1;
                end else begin
                  outgoing_byte_next = i2c_rtc_pkg::BYTE_IDLE;
                end
              end
            end
          end else begin
            unique case (bus_phase) inside
              i2c_rtc_pkg::PH_ADDR: begin
                target_data_drive_next = 1'b1;
              end
              i2c_rtc_pkg::PH_DATA: begin
                if (sending && bit_counter < 4'd8) begin
                  target_data_drive_next = outgoing_byte[3'd7 - bit_counter[2:0]];
                end else begin
                  target_data_drive_next = 1'b1;
                end
              end
              i2c_rtc_pkg::PH_ADDR_ACK, i2c_rtc_pkg::PH_DATA_ACK: begin
                if (bit_counter == 4'd8) begin
                  bit_counter_next = 4'd9;
                  if (bus_phase == i2c_rtc_pkg::PH_ADDR_ACK || !read_direction) begin
                    target_data_drive_next = !target_active;
                  end else begin
                    target_data_drive_next = 1'b1;
                  end
                end else begin
                  bus_phase_next         = i2c_rtc_pkg::PH_DATA;
                  bit_counter_next       = 4'd0;
                  shift_byte_next        = 8'h00;
                  target_data_drive_next = sending ? outgoing_byte[7] : 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      i2c_rtc_pkg::CMD_WR_SDA: begin
        master_data_line_next = in_data.line_value;
        if (clock_line && master_data_line && !in_data.line_value) begin
          bus_phase_next         = i2c_rtc_pkg::PH_ADDR;
          bit_counter_next       = 4'd0;
          shift_byte_next        = 8'h00;
          target_active_next     = 1'b0;
          target_data_drive_next = 1'b1;
        end else if (clock_line && !master_data_line && in_data.line_value) begin
          bus_phase_next         = i2c_rtc_pkg::PH_IDLE;
          target_active_next     = 1'b0;
          target_data_drive_next = 1'b1;
        end
      end
      i2c_rtc_pkg::CMD_RD_SCL: begin
        read_value = i2c_rtc_pkg::READ_MARK | {7'd0, clock_line};
      end
      i2c_rtc_pkg::CMD_RD_SDA: begin
        read_value = i2c_rtc_pkg::READ_MARK | {7'd0, bus_now};
      end
      default: begin
      end
    endcase

    result.read_value      = read_value;
    result.sda_level       = master_data_line_next & target_data_drive_next;
    result.target_selected = target_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address    <= 7'd104;
      clock_line        <= 1'b1;
      master_data_line  <= 1'b1;
      target_data_drive <= 1'b1;
      bus_phase         <= i2c_rtc_pkg::PH_IDLE;
      bit_counter       <= 4'd0;
      shift_byte        <= 8'h00;
      read_direction    <= 1'b0;
      outgoing_byte     <= i2c_rtc_pkg::BYTE_IDLE;
      register_pointer  <= 3'd0;
      pointer_loaded    <= 1'b0;
      target_active     <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        time_registers[i] <= 8'h00;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        target_address <= cfg_data;
      end
      if (accept) begin
        clock_line        <= clock_line_next;
        master_data_line  <= master_data_line_next;
        target_data_drive <= target_data_drive_next;
        bus_phase         <= bus_phase_next;
        bit_counter       <= bit_counter_next;
        shift_byte        <= shift_byte_next;
        read_direction    <= read_direction_next;
        outgoing_byte     <= outgoing_byte_next;
        register_pointer  <= register_pointer_next;
        pointer_loaded    <= pointer_loaded_next;
        target_active     <= target_active_next;
        if (capture) begin
          for (int i = 0; i < REG_COUNT; i++) begin
            time_registers[i] <= (i < 8) ? cap_vals[i[2:0]] : 8'h00;
          end
        end
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule

`default_nettype wire

[hdl/i2c_rtc_chk.sv]
// ---------------------------------------------------------------------------
// i2c_rtc_chk
// Port-level checker for i2c_target_rtc_bitbang, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_target_rtc_bitbang_defines.svh"

module i2c_rtc_chk (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire i2c_rtc_pkg::out_t out_data
);

  logic [7:0] rv;

  assign rv = out_data.read_value;

  `RTC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `RTC_ASSERT_NOW(a_stall_needs_result, clk, rst, in_stall, out_valid)
  `RTC_ASSERT_NEXT(a_transfer_yields_result, clk, rst, in_valid && !in_stall, out_valid)
  `RTC_ASSERT_NOW(a_read_form, clk, rst, out_valid, rv == 8'h00 || rv[7:1] == 7'h7F)

endmodule

bind i2c_target_rtc_bitbang i2c_rtc_chk u_i2c_rtc_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
